[sv/u2gb_pkg.sv]
// Shared types and constants for the UTF-8 to GB2312 converter.
// No dependencies; imported by the controller, datapath and top level.
package u2gb_pkg;

	localparam int TABLE_DEPTH_DEF = 8192;

	localparam logic [7:0]  LEAD_LIMIT  = 8'h80;
	localparam logic [15:0] FALLBACK_GB = 16'hA1A1;

	localparam logic [1:0] PHASE_LEAD  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD = 2'd2;

	localparam logic KIND_TABLE = 1'b0;
	localparam logic KIND_TEXT  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_PROBE   = 4'b0010,
		ST_COMPARE = 4'b0100,
		ST_EMIT_LO = 4'b1000
	} state_t;

	typedef struct packed {
		logic accept;
		logic probe;
		logic narrow;
		logic emit_hi;
		logic use_hit;
		logic emit_lo;
	} cmd_t;

	typedef struct packed {
		logic launch;
		logic empty;
		logic hit;
	} status_t;

endpackage

[sv/u2gb_ctrl.sv]
// Controller FSM: sequences the binary search and the two-beat GB code output.
// Depends on u2gb_pkg; talks to u2gb_datapath through cmd_t and status_t.
module u2gb_ctrl import u2gb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
				if (start && status.launch) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (status.empty) begin
					// range exhausted: key not in table
					cmd.emit_hi = 1'b1;
					state_d     = ST_EMIT_LO;
				end else begin
					cmd.probe = 1'b1;
					state_d   = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				if (status.hit) begin
					cmd.emit_hi = 1'b1;
					cmd.use_hit = 1'b1;
					state_d     = ST_EMIT_LO;
				end else begin
					cmd.narrow = 1'b1;
					state_d    = ST_PROBE;
				end
			end
			ST_EMIT_LO: begin
				cmd.emit_lo = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[sv/u2gb_datapath.sv]
// Datapath: mapping table memory, UTF-8 sequence state, search bounds, output beat.
// Depends on u2gb_pkg; driven by u2gb_ctrl commands.
module u2gb_datapath import u2gb_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        entries_we,
	input  logic [13:0] entries_wdata,
	input  logic        kind,
	input  logic [12:0] table_index,
	input  logic [15:0] table_code_point,
	input  logic [15:0] table_gb_code,
	input  logic [7:0]  text_byte,
	output logic        strobe,
	output logic [7:0]  out_byte,
	output logic        last
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int W     = $clog2(TABLE_DEPTH + 1);

	logic [31:0] mem [TABLE_DEPTH];
	logic [31:0] rd_q;

	logic [13:0]  entries_q;
	logic [1:0]   phase_q;
	logic [3:0]   lead_q;
	logic [5:0]   middle_q;
	logic [15:0]  key_q;
	logic [W-1:0] lo_q, hi_q, mid_q;
	logic [15:0]  gb_q;
	logic         strobe_q;
	logic [7:0]   out_byte_q;
	logic         last_q;

	logic [W-1:0] count_clamped;
	logic [W:0]   mid_sum;
	logic [W-1:0] mid;
	logic         table_wr;
	logic         text_acc;
	logic         pass_beat;
	logic [15:0]  gb_sel;

	assign count_clamped = (32'(entries_q) > 32'(TABLE_DEPTH)) ? W'(TABLE_DEPTH)
	                                                           : W'(entries_q);
	// hi_q is exclusive; probe point matches floor((lo + hi_inclusive) / 2)
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - {{W{1'b0}}, 1'b1};
	assign mid      = mid_sum[W:1];
	assign table_wr = cmd.accept && (kind == KIND_TABLE)
	                  && (32'(table_index) < 32'(TABLE_DEPTH));
	assign text_acc = cmd.accept && (kind == KIND_TEXT);
	assign pass_beat = text_acc && (phase_q != PHASE_SECOND) && (phase_q != PHASE_THIRD)
	                   && (text_byte <= LEAD_LIMIT);
	assign gb_sel   = cmd.use_hit ? rd_q[15:0] : FALLBACK_GB;

	assign status.launch = (kind == KIND_TEXT) && (phase_q == PHASE_THIRD);
	assign status.empty  = (lo_q >= hi_q);
	assign status.hit    = (rd_q[31:16] == key_q);

	always_ff @(posedge clk) begin
		if (table_wr) begin
			mem[IDX_W'(table_index)] <= {table_code_point, table_gb_code};
		end
		if (cmd.probe) begin
			rd_q <= mem[mid[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
			phase_q   <= PHASE_LEAD;
			lead_q    <= '0;
			middle_q  <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= pass_beat || cmd.emit_hi || cmd.emit_lo;
			if (entries_we) begin
				entries_q <= entries_wdata;
			end
			if (text_acc) begin
				case (phase_q)
					PHASE_SECOND: begin
						middle_q <= text_byte[5:0];
						phase_q  <= PHASE_THIRD;
					end
					PHASE_THIRD: begin
						phase_q <= PHASE_LEAD;
					end
					default: begin
						if (text_byte > LEAD_LIMIT) begin
							lead_q  <= text_byte[3:0];
							phase_q <= PHASE_SECOND;
						end else begin
							phase_q <= PHASE_LEAD;
						end
					end
				endcase
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (text_acc && (phase_q == PHASE_THIRD)) begin
			key_q <= {lead_q, middle_q, text_byte[5:0]};
			lo_q  <= '0;
			hi_q  <= count_clamped;
		end
		if (cmd.probe) begin
			mid_q <= mid;
		end
		if (cmd.narrow) begin
			if (rd_q[31:16] > key_q) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + {{(W-1){1'b0}}, 1'b1};
			end
		end
		if (text_acc && (phase_q != PHASE_SECOND) && (phase_q != PHASE_THIRD)) begin
			out_byte_q <= text_byte;
			last_q     <= 1'b1;
		end
		if (cmd.emit_hi) begin
			gb_q       <= gb_sel;
			out_byte_q <= gb_sel[15:8];
			last_q     <= 1'b0;
		end
		if (cmd.emit_lo) begin
			out_byte_q <= gb_q[7:0];
			last_q     <= 1'b1;
		end
	end

	assign strobe   = strobe_q;
	assign out_byte = out_byte_q;
	assign last     = last_q;

endmodule

[sv/utf8_to_gb2312_converter_core.sv]
// Top level of the UTF-8 to GB2312 converter: controller plus datapath.
// Depends on u2gb_pkg, u2gb_ctrl and u2gb_datapath.
//
// An item is taken when start is high and busy is low. Table writes and the
// first two bytes of a three-byte sequence give no beat. A byte up to 0x80
// gives one beat (last high) in the next cycle. The third byte of a sequence
// runs a binary search over the first entries_q table entries (clamped to
// TABLE_DEPTH); each probe is a registered table read (ST_PROBE) followed by
// a compare (ST_COMPARE), with at most ceil(log2(entries+1)) probes while
// busy is high, and gives two beats, high byte then low byte (last high), or
// 0xA1A1 when the code point is absent. Beats appear on strobe for exactly one
// cycle and cannot be stalled; the receiver must take every beat. The table is
// not cleared at reset: only written entries may be searched.
module utf8_to_gb2312_converter_core import u2gb_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [12:0] table_index,
	input  logic [15:0] table_code_point,
	input  logic [15:0] table_gb_code,
	input  logic [7:0]  text_byte,
	input  logic        entries_we,
	input  logic [13:0] entries_wdata,
	output logic        strobe,
	output logic [7:0]  out_byte,
	output logic        last
);

	cmd_t    cmd;
	status_t status;

	u2gb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	u2gb_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.entries_we       (entries_we),
		.entries_wdata    (entries_wdata),
		.kind             (kind),
		.table_index      (table_index),
		.table_code_point (table_code_point),
		.table_gb_code    (table_gb_code),
		.text_byte        (text_byte),
		.strobe           (strobe),
		.out_byte         (out_byte),
		.last             (last)
	);

endmodule
